>>> rtl/dbrw_pkg.sv
// Shared types and constants of the disk bitstream read/write logic.
package dbrw_pkg;

    // Stream payload widths, rounded up to whole bytes.
    localparam int unsigned InDataW  = 16;
    localparam int unsigned OutDataW = 16;

    // Counter and register widths.
    localparam int unsigned BitClkW   = 4;
    localparam int unsigned PhaseW    = 2;
    localparam int unsigned ReadShW   = 10;
    localparam int unsigned WriteShW  = 8;
    localparam int unsigned ByteCntW  = 3;

    // Ten ones in the read shift register mark SYNC.
    localparam logic [ReadShW-1:0]  SyncMask  = 10'h3FF;
    // Byte counter value at which a whole byte has gone by.
    localparam logic [ByteCntW-1:0] CountFull = 3'd7;

    // Input transaction kind, carried in tuser.
    typedef enum logic {
        t_kind_carry   = 1'b0,
        t_kind_refresh = 1'b1
    } t_kind;

    // Bit positions in the input tdata.
    localparam int unsigned InHeadBit   = 0;
    localparam int unsigned InReadMode  = 1;
    localparam int unsigned InWriteMode = 2;
    localparam int unsigned InDisk      = 3;
    localparam int unsigned InBarrier   = 4;
    localparam int unsigned InPortALo   = 5;
    localparam int unsigned InCa2       = 13;

    // Bit positions in the output tdata.
    localparam int unsigned OutSyncN    = 0;
    localparam int unsigned OutReadyN   = 1;
    localparam int unsigned OutEdge     = 2;
    localparam int unsigned OutStrobe   = 3;
    localparam int unsigned OutWriteBit = 4;
    localparam int unsigned OutAdvance  = 5;
    localparam int unsigned OutReadLo   = 6;

endpackage

>>> rtl/disk_bitstream_read_write_logic_unit.sv
// Top level of the disk bitstream read/write logic, one carry pulse or byte-ready refresh per transaction.
//
//  Channel   Dir   tdata (from bit 0 up)                                   tuser
//  s_axis    in    head_bit, read_mode, write_mode, disk_present,          kind
//                  light_barrier, port_a_byte[7:0], ca2_level, 2'b0
//  m_axis    out   sync_n, byte_ready_n, byte_ready_edge, write_strobe,    -
//                  write_bit, advance_head, read_data[7:0], 2'b0
//
// Each accepted transaction updates the drive state and loads its result into the
// output register at the same clock edge, so one transaction per cycle is sustained
// while the receiver keeps up. The single output register is the only buffer: the
// input side is ready whenever that register is empty or being drained this cycle.
// Reset (i_rst_n low, synchronous) empties the output register, clears the
// counters and shift registers and sets byte ready and SYNC to their inactive level.
module disk_bitstream_read_write_logic_unit
    import dbrw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // Bits from 0: head_bit, read_mode, write_mode, disk_present, light_barrier,
    // port_a_byte[7:0], ca2_level, two zero bits.
    input  logic [InDataW-1:0]  s_axis_tdata,
    // Bit 0: kind (0 carry pulse, 1 byte-ready refresh).
    input  logic                s_axis_tuser,
    // Result stream.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // Bits from 0: sync_n, byte_ready_n, byte_ready_edge, write_strobe, write_bit,
    // advance_head, read_data[7:0], two zero bits.
    output logic [OutDataW-1:0] m_axis_tdata
);

    // Drive state.
    logic [BitClkW-1:0]  r_bit_clk, n_bit_clk;
    logic [PhaseW-1:0]   r_phase, n_phase;
    logic [ReadShW-1:0]  r_read_sh, n_read_sh;
    logic [WriteShW-1:0] r_write_sh, n_write_sh;
    logic [ByteCntW-1:0] r_byte_cnt, n_byte_cnt;
    logic                r_ready_lvl, n_ready_lvl;
    logic                r_sync_lvl, n_sync_lvl;

    // Output register.
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data, n_out_data;

    // Unpacked input fields.
    logic                head_bit, read_mode, write_mode, disk_present;
    logic                light_barrier, ca2_level;
    logic [7:0]          port_a_byte;
    t_kind               kind;

    // Per-transaction results.
    logic                strobe, wbit, advance;
    logic                accept;

    assign head_bit      = s_axis_tdata[InHeadBit];
    assign read_mode     = s_axis_tdata[InReadMode];
    assign write_mode    = s_axis_tdata[InWriteMode];
    assign disk_present  = s_axis_tdata[InDisk];
    assign light_barrier = s_axis_tdata[InBarrier];
    assign port_a_byte   = s_axis_tdata[InPortALo +: 8];
    assign ca2_level     = s_axis_tdata[InCa2];
    assign kind          = t_kind'(s_axis_tuser);

    // The output register frees up in the same cycle as it is drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_bit_clk   = r_bit_clk;
        n_phase     = r_phase;
        n_read_sh   = r_read_sh;
        n_write_sh  = r_write_sh;
        n_byte_cnt  = r_byte_cnt;
        n_ready_lvl = r_ready_lvl;
        n_sync_lvl  = r_sync_lvl;
        strobe      = 1'b0;
        wbit        = 1'b0;
        advance     = 1'b0;

        if (kind == t_kind_refresh) begin
            // A CPU cycle only re-evaluates the byte ready line.
            n_ready_lvl = !(ca2_level && !r_bit_clk[1] && (r_byte_cnt == CountFull));
        end else begin
            n_bit_clk = r_bit_clk + 1'b1;
            n_phase   = r_phase + 1'b1;

            // Every fourth carry pulse a present disk moves on by one bit; a one under
            // the head in read mode resynchronises the bit clock.
            if (n_phase == '0) begin
                if (read_mode && disk_present && head_bit) begin
                    n_bit_clk = '0;
                end
                advance = disk_present;
            end

            // SYNC is sampled from the shift register as it stood before this pulse.
            n_sync_lvl = (r_read_sh != SyncMask) || write_mode;
            if (!n_sync_lvl) begin
                n_byte_cnt = '0;
            end

            case (n_bit_clk[1:0]) inside
                2'd0, 2'd1: begin
                    n_ready_lvl = !(ca2_level && !n_bit_clk[1] && (n_byte_cnt == CountFull));
                end
                2'd2: begin
                    n_ready_lvl = 1'b1;
                    n_byte_cnt  = n_sync_lvl ? n_byte_cnt + 1'b1 : '0;
                    if (write_mode && disk_present && !light_barrier) begin
                        strobe = 1'b1;
                        wbit   = r_write_sh[WriteShW-1];
                    end
                    n_write_sh = {r_write_sh[WriteShW-2:0], 1'b0};
                    // A new bit is a one when the upper counter bits are clear,
                    // that is shortly after the last flux transition.
                    n_read_sh  = {r_read_sh[ReadShW-2:0], (n_bit_clk[3:2] == 2'b00)};
                end
                default: begin
                    if (n_byte_cnt == CountFull) begin
                        n_write_sh = port_a_byte;
                    end
                end
            endcase
        end

        n_out_data              = '0;
        n_out_data[OutSyncN]    = n_sync_lvl;
        n_out_data[OutReadyN]   = n_ready_lvl;
        n_out_data[OutEdge]     = n_ready_lvl != r_ready_lvl;
        n_out_data[OutStrobe]   = strobe;
        n_out_data[OutWriteBit] = wbit;
        n_out_data[OutAdvance]  = advance;
        n_out_data[OutReadLo +: 8] = n_read_sh[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_clk   <= '0;
            r_phase     <= '0;
            r_read_sh   <= '0;
            r_write_sh  <= '0;
            r_byte_cnt  <= '0;
            r_ready_lvl <= 1'b1;
            r_sync_lvl  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_bit_clk   <= n_bit_clk;
                r_phase     <= n_phase;
                r_read_sh   <= n_read_sh;
                r_write_sh  <= n_write_sh;
                r_byte_cnt  <= n_byte_cnt;
                r_ready_lvl <= n_ready_lvl;
                r_sync_lvl  <= n_sync_lvl;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when a transaction is accepted.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/dbrw_checker.sv
// Port-level checker for the disk bitstream read/write logic and its bind.
module dbrw_checker
    import dbrw_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An empty output register never holds back the input.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with empty output register");

    // A written bit is only reported together with its strobe.
    a_wbit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OutWriteBit] |-> m_axis_tdata[OutStrobe])
        else $error("write bit without write strobe");

    // The shift phase always drops byte ready, so a strobe never sees it active.
    a_strobe_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OutStrobe] |-> m_axis_tdata[OutReadyN])
        else $error("byte ready active during a shift");

    // An accepted transaction shows up as a result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted transaction gave no result");

endmodule

bind disk_bitstream_read_write_logic_unit dbrw_checker u_dbrw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/disk_bitstream_read_write_logic_unit_tb.sv
// Self-checking testbench for the disk bitstream read/write logic unit.
module disk_bitstream_read_write_logic_unit_tb
    import dbrw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transaction on either port before the run is abandoned.
    localparam int unsigned QuietLimit = 5000;
    // Cycles allowed after the last result for a stray extra result to show up.
    localparam int unsigned DrainCycles = 8;
    // Items wanted in total, directed part included.
    localparam int unsigned ItemTarget = 1150;
    // Accepted-pulse count at which the receiver holds off, and for how long.
    localparam int unsigned HoldStart = 150;
    localparam int unsigned HoldCycles = 60;
    // Mismatch lines printed before further ones are only counted.
    localparam int unsigned ReportCap = 30;

    // One input transaction as the stimulus sees it.
    typedef struct packed {
        t_kind      kind;
        logic       head;
        logic       rmode;
        logic       wmode;
        logic       disk;
        logic       barrier;
        logic [7:0] port_a;
        logic       ca2;
    } t_pulse;

    // One result transaction, field by field.
    typedef struct packed {
        logic       sync_n;
        logic       ready_n;
        logic       ready_edge;
        logic       strobe;
        logic       wbit;
        logic       advance;
        logic [7:0] read_lo;
    } t_drive_out;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // Bits from 0: head_bit, read_mode, write_mode, disk_present, light_barrier,
    // port_a_byte[7:0], ca2_level, two zero bits.
    logic [InDataW-1:0]  s_axis_tdata = '0;
    // Bit 0: kind.
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // Bits from 0: sync_n, byte_ready_n, byte_ready_edge, write_strobe, write_bit,
    // advance_head, read_data[7:0], two zero bits.
    logic [OutDataW-1:0] m_axis_tdata;

    disk_bitstream_read_write_logic_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Items waiting to be offered; the head of the queue is the one on the bus.
    t_pulse      pulse_queue[$];
    // Results the drive logic owes, oldest first.
    t_drive_out  due_outputs[$];
    int unsigned pulses_in = 0;
    int unsigned n_errors = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          pulse_taken = 1'b0;
    // Number of carry pulses queued so far, used to line data bits up with the
    // fourth pulse of each bit cell.
    int unsigned carries_queued = 0;

    // Private copy of the drive state, kept in step with accepted transactions.
    logic [3:0] bclk_cnt;
    logic [1:0] carry_ph;
    logic [9:0] rd_shift;
    logic [7:0] wr_shift;
    logic [2:0] bits_in_byte;
    logic       ready_lvl;
    logic       sync_lvl;

    initial begin
        bclk_cnt     = '0;
        carry_ph     = '0;
        rd_shift     = '0;
        wr_shift     = '0;
        bits_in_byte = '0;
        ready_lvl    = 1'b1;
        sync_lvl     = 1'b1;
    end

    // Advances the private drive state by one transaction and returns the result
    // that the block should give for it.
    function automatic t_drive_out step_drive(t_pulse p);
        t_drive_out r;
        logic       was_ready;
        was_ready = ready_lvl;
        r = '0;
        if (p.kind == t_kind_refresh) begin
            ready_lvl = !(p.ca2 && !bclk_cnt[1] && bits_in_byte == CountFull);
        end else begin
            bclk_cnt = bclk_cnt + 4'd1;
            carry_ph = carry_ph + 2'd1;
            // Every fourth pulse the disk turns by one bit; a one under the head
            // in read mode restarts the bit clock.
            if (carry_ph == 2'd0) begin
                if (p.rmode && p.disk && p.head) begin
                    bclk_cnt = '0;
                end
                r.advance = p.disk;
            end
            sync_lvl = (rd_shift != SyncMask) || p.wmode;
            if (!sync_lvl) begin
                bits_in_byte = '0;
            end
            case (bclk_cnt[1:0]) inside
                2'd0, 2'd1: begin
                    ready_lvl = !(p.ca2 && !bclk_cnt[1] && bits_in_byte == CountFull);
                end
                2'd2: begin
                    ready_lvl = 1'b1;
                    bits_in_byte = sync_lvl ? bits_in_byte + 3'd1 : 3'd0;
                    if (p.wmode && p.disk && !p.barrier) begin
                        r.strobe = 1'b1;
                        r.wbit   = wr_shift[7];
                    end
                    wr_shift = {wr_shift[6:0], 1'b0};
                    // A one is read when the bit clock is still in its first four
                    // counts, that is when no long run of zeros has gone by.
                    rd_shift = {rd_shift[8:0], bclk_cnt[3:2] == 2'b00};
                end
                default: begin
                    if (bits_in_byte == CountFull) begin
                        wr_shift = p.port_a;
                    end
                end
            endcase
        end
        r.sync_n     = sync_lvl;
        r.ready_n    = ready_lvl;
        r.ready_edge = was_ready != ready_lvl;
        r.read_lo    = rd_shift[7:0];
        return r;
    endfunction

    // Prints one line per discrepancy, up to a cap, and counts every one of them.
    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= ReportCap) begin
            $display("ERROR %0t ns: %s got %0d, wanted %0d", $time, what, got, want);
        end
    endtask

    // Appends one transaction to the stimulus and keeps the carry pulse count.
    task automatic push_pulse(input t_pulse p);
        pulse_queue.push_back(p);
        if (p.kind == t_kind_carry) begin
            carries_queued++;
        end
    endtask

    // Queues the four carry pulses of one bit cell. The data bit sits on the
    // pulse that completes the carry phase; the head bit on the others does not
    // matter and is random. Now and then a byte-ready refresh is slipped in, as
    // a CPU cycle would do.
    task automatic push_cell(input logic data_bit, input t_pulse run);
        t_pulse p;
        t_pulse r;
        for (int k = 0; k < 4; k++) begin
            p        = run;
            p.kind   = t_kind_carry;
            p.head   = (carries_queued % 4 == 3) ? data_bit : 1'($urandom_range(1));
            p.port_a = 8'($urandom_range(255));
            push_pulse(p);
            if ($urandom_range(99) < 8) begin
                r      = run;
                r.kind = t_kind_refresh;
                r.head = 1'($urandom_range(1));
                r.port_a = 8'($urandom_range(255));
                push_pulse(r);
            end
        end
    endtask

    // Stimulus, reset and the end of the run.
    initial begin : stimulus
        t_pulse p;
        t_pulse run;
        int     n_sync;
        int     n_bytes;
        int     n_noise;

        // Directed part. Refresh transactions straight after reset, with CA2 both
        // ways.
        p = '{kind: t_kind_refresh, head: 1'b1, rmode: 1'b1, wmode: 1'b0, disk: 1'b1,
              barrier: 1'b0, port_a: 8'hFF, ca2: 1'b1};
        push_pulse(p);
        p.ca2 = 1'b0;
        p.port_a = 8'h00;
        push_pulse(p);
        // Seventeen pulses with no disk: the head never advances, no head bit
        // clears the bit clock and the counter wraps past fifteen.
        for (int k = 0; k < 17; k++) begin
            p = '{kind: t_kind_carry, head: 1'b1, rmode: 1'b1, wmode: 1'b0, disk: 1'b0,
                  barrier: k[0], port_a: k[0] ? 8'hFF : 8'h00, ca2: k[1]};
            push_pulse(p);
        end
        // Both modes at once with a disk: write mode holds SYNC off while the
        // head bits still restart the bit clock; the light barrier is raised on
        // the last two pulses.
        for (int k = 0; k < 4; k++) begin
            p = '{kind: t_kind_carry, head: 1'b1, rmode: 1'b1, wmode: 1'b1, disk: 1'b1,
                  barrier: k[1], port_a: 8'hA5 ^ 8'(k), ca2: 1'b1};
            push_pulse(p);
        end

        // Random part. Mostly whole frames: a SYNC mark of ten or more ones and a
        // few bytes of ten random bits each, under one set of mode lines. The rest
        // is short bursts of fully random transactions that break the bit cells.
        while (pulse_queue.size() < ItemTarget) begin
            if ($urandom_range(99) < 85) begin
                run.kind    = t_kind_carry;
                run.head    = 1'b0;
                run.wmode   = ($urandom_range(99) < 25);
                run.rmode   = run.wmode ? 1'($urandom_range(1)) : ($urandom_range(99) < 92);
                run.disk    = ($urandom_range(99) < 92);
                run.barrier = ($urandom_range(99) < 20);
                run.port_a  = '0;
                run.ca2     = ($urandom_range(99) < 80);
                n_sync  = $urandom_range(14, 10);
                n_bytes = $urandom_range(3, 1);
                for (int k = 0; k < n_sync; k++) begin
                    push_cell(1'b1, run);
                end
                for (int k = 0; k < n_bytes * 10; k++) begin
                    push_cell(1'($urandom_range(1)), run);
                end
            end else begin
                n_noise = $urandom_range(8, 1);
                for (int k = 0; k < n_noise; k++) begin
                    p.kind    = ($urandom_range(3) == 0) ? t_kind_refresh : t_kind_carry;
                    p.head    = 1'($urandom_range(1));
                    p.rmode   = 1'($urandom_range(1));
                    p.wmode   = 1'($urandom_range(1));
                    p.disk    = 1'($urandom_range(1));
                    p.barrier = 1'($urandom_range(1));
                    p.port_a  = 8'($urandom_range(255));
                    p.ca2     = 1'($urandom_range(1));
                    push_pulse(p);
                end
            end
        end
        // The last frame may run past the wanted count; its tail is dropped.
        while (pulse_queue.size() > ItemTarget) begin
            void'(pulse_queue.pop_back());
        end

        // Reset is held low from the start of the run and released on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait until every item has been taken and every result has come back,
        // then wait DrainCycles more cycles in which any stray result would show.
        while (pulse_queue.size() != 0 || due_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("disk_bitstream_read_write_logic_unit: match");
        end else begin
            $display("disk_bitstream_read_write_logic_unit: mismatch");
        end
        $finish;
    end

    // Driver. Once an item is offered it stays on the bus unchanged until the
    // transaction completes. Between items the sender may idle, with a rate that
    // depends on how far the run has got.
    always @(negedge i_clk) begin : drive_pulses
        int unsigned idle_pct;
        if (pulses_in >= 320 && pulses_in < 560) begin
            idle_pct = 70;
        end else if (pulses_in >= 800 && pulses_in < 1040) begin
            idle_pct = 11;
        end else begin
            idle_pct = 0;
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !pulse_taken) begin
            // Still waiting for the current item to be accepted.
        end else if (pulse_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {2'b00, pulse_queue[0].ca2, pulse_queue[0].port_a,
                              pulse_queue[0].barrier, pulse_queue[0].disk,
                              pulse_queue[0].wmode, pulse_queue[0].rmode,
                              pulse_queue[0].head};
            s_axis_tuser  <= pulse_queue[0].kind;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Long hold-off of the receiver: once, a stretch of cycles counted here, while
    // the sender keeps offering, so the output register fills and input stalls.
    always @(negedge i_clk) begin
        if (i_rst_n && !hold_done && pulses_in >= HoldStart) begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver. Stalls at random in some stretches of the run, and throughout the
    // long hold-off.
    always @(negedge i_clk) begin : drive_ready
        int unsigned stall_pct;
        if (pulses_in >= 560 && pulses_in < 800) begin
            stall_pct = 70;
        end else if (pulses_in >= 800 && pulses_in < 1040) begin
            stall_pct = 11;
        end else begin
            stall_pct = 0;
        end
        m_axis_tready <= i_rst_n && hold_left == 0 && $urandom_range(99) >= stall_pct;
    end

    // Monitor for both ports. A result leaving the block is checked against the
    // oldest result due before the transaction accepted at the same edge adds its
    // own, so the order of the two within the edge never matters.
    always @(posedge i_clk) begin : watch_ports
        t_drive_out got;
        t_drive_out want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.sync_n     = m_axis_tdata[OutSyncN];
                got.ready_n    = m_axis_tdata[OutReadyN];
                got.ready_edge = m_axis_tdata[OutEdge];
                got.strobe     = m_axis_tdata[OutStrobe];
                got.wbit       = m_axis_tdata[OutWriteBit];
                got.advance    = m_axis_tdata[OutAdvance];
                got.read_lo    = m_axis_tdata[OutReadLo +: 8];
                if (due_outputs.size() == 0) begin
                    report_mismatch("result with nothing due, tdata", int'(m_axis_tdata), 0);
                end else begin
                    want = due_outputs.pop_front();
                    if (got.sync_n !== want.sync_n)
                        report_mismatch("sync_n", int'(got.sync_n), int'(want.sync_n));
                    if (got.ready_n !== want.ready_n)
                        report_mismatch("byte_ready_n", int'(got.ready_n),
                                        int'(want.ready_n));
                    if (got.ready_edge !== want.ready_edge)
                        report_mismatch("byte_ready_edge", int'(got.ready_edge),
                                        int'(want.ready_edge));
                    if (got.strobe !== want.strobe)
                        report_mismatch("write_strobe", int'(got.strobe), int'(want.strobe));
                    if (got.wbit !== want.wbit)
                        report_mismatch("write_bit", int'(got.wbit), int'(want.wbit));
                    if (got.advance !== want.advance)
                        report_mismatch("advance_head", int'(got.advance),
                                        int'(want.advance));
                    if (got.read_lo !== want.read_lo)
                        report_mismatch("read_data", int'(got.read_lo), int'(want.read_lo));
                end
            end
            pulse_taken = s_axis_tvalid && s_axis_tready;
            if (pulse_taken) begin
                due_outputs.push_back(step_drive(pulse_queue.pop_front()));
                pulses_in++;
            end
        end
    end

    // Watchdog: a long run of cycles in which neither port moves a transaction
    // means the block has hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QuietLimit) begin
                $display("disk_bitstream_read_write_logic_unit: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
